[hw/rtl/ewc_pkg.sv]
`default_nettype none
package ewc_pkg;

  // Slot and rank fields are carried at the width of the largest directory.
  localparam int unsigned SEL_W = 8;
  localparam int unsigned ID_W = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BANK = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FAIL   = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_MISS,
    UPD_FAIL,
    UPD_FLUSH
  } upd_op_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] expert_id;
  } ewc_in_t;

  typedef struct packed {
    logic            hit;
    logic [4:0]      slot;
    logic            evicted_valid;
    logic [ID_W-1:0] evicted_id;
    logic            use_cpu_bank;
    logic [7:0]      local_index;
    logic            route_error;
  } ewc_res_t;

  typedef struct packed {
    upd_op_e          op;
    logic [SEL_W-1:0] slot;
    logic [SEL_W-1:0] rank;
    logic [ID_W-1:0]  tag;
  } ewc_upd_t;

  typedef struct packed {
    logic             hit_found;
    logic [SEL_W-1:0] hit_slot;
    logic [SEL_W-1:0] hit_rank;
    logic             free_found;
    logic [SEL_W-1:0] free_slot;
    logic             max_set;
    logic [SEL_W-1:0] max_slot;
    logic [SEL_W-1:0] max_rank;
    logic [ID_W-1:0]  max_tag;
  } ewc_pkt_t;

endpackage
`default_nettype wire

[hw/rtl/ewc_cell.sv]
`default_nettype none
module ewc_cell import ewc_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = 32,
  parameter int unsigned IDX = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [ID_W-1:0] id_i,
  input  wire ewc_upd_t        upd_i,
  input  wire ewc_pkt_t        pkt_i,
  output ewc_pkt_t             pkt_o
);

  localparam int unsigned RANK_W = $clog2(CACHE_ENTRIES);
  localparam logic [SEL_W-1:0] MY_SLOT = SEL_W'(IDX);

  logic [ID_W-1:0]   tag_q, tag_d;
  logic              valid_q, valid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [SEL_W-1:0]  rank_ext;
  logic              is_me;
  ewc_pkt_t          pkt_q, pkt_d;

  assign rank_ext = SEL_W'(rank_q);
  assign is_me = (upd_i.slot == MY_SLOT);

  always_comb begin
    pkt_d = pkt_i;
    if (valid_q && (tag_q == id_i) && !pkt_i.hit_found) begin
      pkt_d.hit_found = 1'b1;
      pkt_d.hit_slot  = MY_SLOT;
      pkt_d.hit_rank  = rank_ext;
    end
    if (!valid_q && !pkt_i.free_found) begin
      pkt_d.free_found = 1'b1;
      pkt_d.free_slot  = MY_SLOT;
    end
    if (!pkt_i.max_set || (rank_ext > pkt_i.max_rank)) begin
      pkt_d.max_set  = 1'b1;
      pkt_d.max_slot = MY_SLOT;
      pkt_d.max_rank = rank_ext;
      pkt_d.max_tag  = tag_q;
    end
  end

  always_comb begin
    tag_d   = tag_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    case (upd_i.op)
      UPD_HIT: begin
        if (is_me) begin
          rank_d = '0;
        end else if (valid_q && (rank_ext < upd_i.rank)) begin
          rank_d = rank_q + 1'b1;
        end
      end
      UPD_MISS: begin
        if (is_me) begin
          tag_d   = upd_i.tag;
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
      UPD_FAIL: begin
        if (is_me) begin
          valid_d = 1'b0;
          rank_d  = '0;
        end else if (valid_q && (rank_ext > upd_i.rank)) begin
          rank_d = rank_q - 1'b1;
        end
      end
      UPD_FLUSH: begin
        valid_d = 1'b0;
        rank_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    pkt_q <= pkt_d;
  end

  assign pkt_o = pkt_q;

endmodule
`default_nettype wire

[hw/rtl/ewc_ctrl.sv]
`default_nettype none
module ewc_ctrl import ewc_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = 32,
  parameter int unsigned NUM_EXPERTS = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ewc_in_t               in_i,
  output logic                       done_o,
  output ewc_res_t                   res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [ID_W-1:0]            id_o,
  output ewc_upd_t                   upd_o,
  input  wire ewc_pkt_t              pkt_i
);

  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CACHE_ENTRIES - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  ewc_in_t          in_q;
  logic [8:0]       pivot_q;
  logic             cpu_bank_q;
  logic [IDX_W-1:0] last_slot_q, last_slot_d;
  logic             pending_q, pending_d;
  logic             done_q, done_d;
  ewc_res_t         res_q, res_d;
  logic             accept;
  logic [SEL_W-1:0] miss_slot;
  logic             route_cpu, route_err;
  logic [7:0]       route_local;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);
  assign id_o   = in_q.expert_id;

  assign miss_slot = pkt_i.free_found ? pkt_i.free_slot : pkt_i.max_slot;

  always_comb begin
    route_cpu   = 1'b0;
    route_err   = 1'b0;
    route_local = '0;
    if (32'(in_q.expert_id) >= 32'(NUM_EXPERTS)) begin
      route_err = 1'b1;
    end else if ((pivot_q != '0) && (9'(in_q.expert_id) < pivot_q)) begin
      if (cpu_bank_q) begin
        route_cpu   = 1'b1;
        route_local = in_q.expert_id;
      end else begin
        route_err = 1'b1;
      end
    end else begin
      route_local = 8'(9'(in_q.expert_id) - pivot_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_slot_d = last_slot_q;
    pending_d   = pending_q;
    done_d      = 1'b0;
    res_d       = res_q;
    upd_o       = '{op: UPD_NONE, slot: '0, rank: '0, tag: in_q.expert_id};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = (in_i.mode == MODE_LOOKUP) ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        res_d   = '0;
        case (in_q.mode)
          MODE_LOOKUP: begin
            res_d.use_cpu_bank = route_cpu;
            res_d.local_index  = route_local;
            res_d.route_error  = route_err;
            if (pkt_i.hit_found) begin
              upd_o.op   = UPD_HIT;
              upd_o.slot = pkt_i.hit_slot;
              upd_o.rank = pkt_i.hit_rank;
              res_d.hit  = 1'b1;
              res_d.slot = 5'(pkt_i.hit_slot);
              pending_d  = 1'b0;
            end else begin
              upd_o.op            = UPD_MISS;
              upd_o.slot          = miss_slot;
              res_d.slot          = 5'(miss_slot);
              res_d.evicted_valid = !pkt_i.free_found;
              res_d.evicted_id    = pkt_i.free_found ? '0 : pkt_i.max_tag;
              pending_d           = 1'b1;
              last_slot_d         = IDX_W'(miss_slot);
            end
          end
          MODE_FAIL: begin
            if (pending_q) begin
              upd_o.op   = UPD_FAIL;
              upd_o.slot = SEL_W'(last_slot_q);
              res_d.slot = 5'(last_slot_q);
            end
            pending_d = 1'b0;
          end
          MODE_FLUSH: begin
            upd_o.op  = UPD_FLUSH;
            pending_d = 1'b0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_slot_q <= '0;
      pending_q   <= 1'b0;
      done_q      <= 1'b0;
      pivot_q     <= '0;
      cpu_bank_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_slot_q <= last_slot_d;
      pending_q   <= pending_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PIVOT:    pivot_q    <= cfg_wdata_i;
          CFG_CPU_BANK: cpu_bank_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == ST_DECIDE) && (state_q == ST_IDLE))
    else $error("result strobe without a decide cycle");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.hit) |-> !res_q.evicted_valid)
    else $error("hit reported an eviction");

  a_route_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.route_error) |-> (!res_q.use_cpu_bank && (res_q.local_index == '0)))
    else $error("route error with nonzero routing fields");

  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (cnt_q == LAST_CELL)) |=> (state_q == ST_DECIDE))
    else $error("scan did not end after the last cell");

  a_miss_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !res_q.hit && (in_q.mode == MODE_LOOKUP)) |-> pending_q)
    else $error("miss left no pending fill");

endmodule
`default_nettype wire

[hw/rtl/expert_weight_lru_cache.sv]
// Channel  Handshake           Payload
// input    start / busy        in_i (ewc_in_t: mode, expert_id)
// result   done_o strobe       res_o (ewc_res_t)
// config   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// A lookup passes the scan state, where the search packet moves one cell per cycle
// down the chain, then the decide state decides and updates the cells.
// A fill failure, a flush or an unused mode goes straight to the decide state.
// Reset clears all valid bits, ranks, the pending fill and both registers.
// done_o is high for one cycle only, while res_o holds until the next decision; the
// receiver cannot stall them, and a new item may start in the cycle of the strobe.
`default_nettype none
module expert_weight_lru_cache import ewc_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = 32,
  parameter int unsigned NUM_EXPERTS = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ewc_in_t               in_i,
  output logic                       done_o,
  output ewc_res_t                   res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [ID_W-1:0] id_w;
  ewc_upd_t        upd_w;
  ewc_pkt_t        pkt_w [0:CACHE_ENTRIES];

  assign pkt_w[0] = '0;

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    ewc_cell #(
      .CACHE_ENTRIES(CACHE_ENTRIES),
      .IDX(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .id_i  (id_w),
      .upd_i (upd_w),
      .pkt_i (pkt_w[k]),
      .pkt_o (pkt_w[k+1])
    );
  end

  ewc_ctrl #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .NUM_EXPERTS(NUM_EXPERTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .id_o       (id_w),
    .upd_o      (upd_w),
    .pkt_i      (pkt_w[CACHE_ENTRIES])
  );

endmodule
`default_nettype wire
